[rtl/core/sorted_priority_queue_top_macros.svh]
// Assertion macros shared by the priority queue RTL.
`ifndef SORTED_PRIORITY_QUEUE_TOP_MACROS_SVH
`define SORTED_PRIORITY_QUEUE_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SPQ_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SPQ_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/spq_pkg.sv]
// Package for the sorted priority queue: defaults, opcode, cell command and cell control types.
package spq_pkg;

    localparam int DEF_QUEUE_DEPTH = 64;
    localparam int DEF_VALUE_BITS  = 16;
    localparam int DEF_PRIO_BITS   = 8;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_REMOVE = 1'b1
    } t_opcode;

    typedef enum logic [1:0] {
        CMD_HOLD,
        CMD_INSERT,
        CMD_REMOVE
    } t_cmd;

    typedef struct packed {
        t_cmd cmd;
        logic occ;        // cell holds a live entry
        logic left_keep;  // left neighbour keeps its entry on insert
    } t_cell_ctl;

endpackage

[rtl/core/spq_cell.sv]
// One slot of the sorted queue: holds an entry and shifts it to or from its neighbours.
module spq_cell #(
    parameter int VALUE_BITS = spq_pkg::DEF_VALUE_BITS,
    parameter int PRIO_BITS  = spq_pkg::DEF_PRIO_BITS
) (
    input  logic                  i_clk,
    input  spq_pkg::t_cell_ctl    i_ctl,
    input  logic [VALUE_BITS-1:0] i_new_value,
    input  logic [PRIO_BITS-1:0]  i_new_prio,
    input  logic [VALUE_BITS-1:0] i_left_value,
    input  logic [PRIO_BITS-1:0]  i_left_prio,
    input  logic [VALUE_BITS-1:0] i_right_value,
    input  logic [PRIO_BITS-1:0]  i_right_prio,
    output logic [VALUE_BITS-1:0] o_value,
    output logic [PRIO_BITS-1:0]  o_prio,
    output logic                  o_keep
);

    logic [VALUE_BITS-1:0] r_value;
    logic [PRIO_BITS-1:0]  r_prio;
    logic [VALUE_BITS-1:0] n_value;
    logic [PRIO_BITS-1:0]  n_prio;

    // live entry not after the new one: it stays put (ties keep arrival order)
    assign o_keep = i_ctl.occ && (r_prio <= i_new_prio);

    always_comb begin
        n_value = r_value;
        n_prio  = r_prio;
        unique case (i_ctl.cmd)
            spq_pkg::CMD_INSERT: begin
                if (o_keep) begin
                    n_value = r_value;
                    n_prio  = r_prio;
                end else if (i_ctl.left_keep) begin
                    n_value = i_new_value;
                    n_prio  = i_new_prio;
                end else begin
                    n_value = i_left_value;
                    n_prio  = i_left_prio;
                end
            end
            spq_pkg::CMD_REMOVE: begin
                n_value = i_right_value;
                n_prio  = i_right_prio;
            end
            default: begin
                n_value = r_value;
                n_prio  = r_prio;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
        r_prio  <= n_prio;
    end

    assign o_value = r_value;
    assign o_prio  = r_prio;

endmodule

[rtl/core/sorted_priority_queue_top.sv]
// Top level of the sorted priority queue: row of slot cells, entry count and result register.
//
//  channel  | direction | handshake          | words
//  ---------+-----------+--------------------+--------------------------------------------
//  command  | in        | i_start / o_busy   | i_opcode, i_item_value, i_item_priority
//  result   | out       | o_valid (strobe)   | o_removed_*, flags, o_entry_count, o_head_*
//
// A command word is taken on any edge with i_start high; o_busy is never raised,
// so one word per cycle is sustained. Each slot cell compares its priority with the
// incoming one and shifts when the row registers update, so the result strobe is high in
// the cycle after the command is accepted. Reset (synchronous, active low) clears the entry
// count and the strobe; slot contents are left as they are and read only below the
// count. The receiver cannot stall: each result word is on the ports for one cycle.
`include "sorted_priority_queue_top_macros.svh"

module sorted_priority_queue_top #(
    parameter int QUEUE_DEPTH = spq_pkg::DEF_QUEUE_DEPTH,
    parameter int VALUE_BITS  = spq_pkg::DEF_VALUE_BITS,
    parameter int PRIO_BITS   = spq_pkg::DEF_PRIO_BITS,
    parameter int CNT_BITS    = $clog2(QUEUE_DEPTH + 1)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    output logic                  o_busy,
    input  logic                  i_opcode,
    input  logic [VALUE_BITS-1:0] i_item_value,
    input  logic [PRIO_BITS-1:0]  i_item_priority,
    output logic                  o_valid,
    output logic [VALUE_BITS-1:0] o_removed_value,
    output logic [PRIO_BITS-1:0]  o_removed_priority,
    output logic                  o_removed_valid,
    output logic                  o_empty_error,
    output logic                  o_full_drop,
    output logic [CNT_BITS-1:0]   o_entry_count,
    output logic [VALUE_BITS-1:0] o_head_value,
    output logic [PRIO_BITS-1:0]  o_head_priority,
    output logic                  o_head_valid
);

    localparam logic [CNT_BITS-1:0] FULL_CNT = CNT_BITS'(QUEUE_DEPTH);

    logic                  accept;
    logic                  is_full;
    logic                  is_empty;
    spq_pkg::t_cmd         cmd;

    logic [CNT_BITS-1:0]   r_count;
    logic [CNT_BITS-1:0]   n_count;

    logic                  r_valid;
    logic                  r_rem_valid;
    logic                  r_empty_err;
    logic                  r_full_drop;
    logic [VALUE_BITS-1:0] r_rem_value;
    logic [PRIO_BITS-1:0]  r_rem_prio;
    logic                  n_rem_valid;
    logic                  n_empty_err;
    logic                  n_full_drop;
    logic [VALUE_BITS-1:0] n_rem_value;
    logic [PRIO_BITS-1:0]  n_rem_prio;

    logic [VALUE_BITS-1:0] cell_value [QUEUE_DEPTH];
    logic [PRIO_BITS-1:0]  cell_prio  [QUEUE_DEPTH];
    logic                  cell_keep  [QUEUE_DEPTH];

    assign o_busy   = 1'b0;
    assign accept   = i_start && !o_busy;
    assign is_full  = (r_count == FULL_CNT);
    assign is_empty = (r_count == '0);

    // broadcast command to every cell; rejected operations leave the row alone
    always_comb begin
        cmd         = spq_pkg::CMD_HOLD;
        n_count     = r_count;
        n_rem_valid = 1'b0;
        n_empty_err = 1'b0;
        n_full_drop = 1'b0;
        n_rem_value = '0;
        n_rem_prio  = '0;
        if (accept) begin
            unique case (spq_pkg::t_opcode'(i_opcode))
                spq_pkg::OP_INSERT: begin
                    if (is_full) begin
                        n_full_drop = 1'b1;
                    end else begin
                        cmd     = spq_pkg::CMD_INSERT;
                        n_count = r_count + 1'b1;
                    end
                end
                spq_pkg::OP_REMOVE: begin
                    if (is_empty) begin
                        n_empty_err = 1'b1;
                    end else begin
                        cmd         = spq_pkg::CMD_REMOVE;
                        n_count     = r_count - 1'b1;
                        n_rem_valid = 1'b1;
                        n_rem_value = cell_value[0];
                        n_rem_prio  = cell_prio[0];
                    end
                end
                default: begin
                    cmd = spq_pkg::CMD_HOLD;
                end
            endcase
        end
    end

    // slot row: cell 0 is the head, data moves right on insert and left on remove
    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
        spq_pkg::t_cell_ctl    ctl;
        logic [VALUE_BITS-1:0] left_value;
        logic [PRIO_BITS-1:0]  left_prio;
        logic [VALUE_BITS-1:0] right_value;
        logic [PRIO_BITS-1:0]  right_prio;

        if (g == 0) begin : g_first
            assign ctl.left_keep = 1'b1;
            assign left_value    = i_item_value;
            assign left_prio     = i_item_priority;
        end else begin : g_inner
            assign ctl.left_keep = cell_keep[g-1];
            assign left_value    = cell_value[g-1];
            assign left_prio     = cell_prio[g-1];
        end

        if (g == QUEUE_DEPTH - 1) begin : g_last
            assign right_value = cell_value[g];
            assign right_prio  = cell_prio[g];
        end else begin : g_body
            assign right_value = cell_value[g+1];
            assign right_prio  = cell_prio[g+1];
        end

        assign ctl.cmd = cmd;
        assign ctl.occ = (r_count > CNT_BITS'(g));

        spq_cell #(
            .VALUE_BITS (VALUE_BITS),
            .PRIO_BITS  (PRIO_BITS)
        ) u_cell (
            .i_clk         (i_clk),
            .i_ctl         (ctl),
            .i_new_value   (i_item_value),
            .i_new_prio    (i_item_priority),
            .i_left_value  (left_value),
            .i_left_prio   (left_prio),
            .i_right_value (right_value),
            .i_right_prio  (right_prio),
            .o_value       (cell_value[g]),
            .o_prio        (cell_prio[g]),
            .o_keep        (cell_keep[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_valid     <= 1'b0;
            r_rem_valid <= 1'b0;
            r_empty_err <= 1'b0;
            r_full_drop <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_valid     <= accept;
            r_rem_valid <= n_rem_valid;
            r_empty_err <= n_empty_err;
            r_full_drop <= n_full_drop;
        end
    end

    // payload of the removed word, no reset needed
    always_ff @(posedge i_clk) begin
        r_rem_value <= n_rem_value;
        r_rem_prio  <= n_rem_prio;
    end

    // head and count read straight from the row after the update
    assign o_valid            = r_valid;
    assign o_removed_value    = r_rem_value;
    assign o_removed_priority = r_rem_prio;
    assign o_removed_valid    = r_rem_valid;
    assign o_empty_error      = r_empty_err;
    assign o_full_drop        = r_full_drop;
    assign o_entry_count      = r_count;
    assign o_head_valid       = !is_empty;
    assign o_head_value       = is_empty ? '0 : cell_value[0];
    assign o_head_priority    = is_empty ? '0 : cell_prio[0];

    `SPQ_ASSERT_IMP(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= FULL_CNT, "count above depth")
    `SPQ_ASSERT_NXT(a_strobe_follows, i_clk, i_rst_n, accept, r_valid, "missing result strobe")
    `SPQ_ASSERT_NXT(a_no_phantom, i_clk, i_rst_n, !accept, !r_valid, "result without command")
    `SPQ_ASSERT_IMP(a_flags_excl, i_clk, i_rst_n, r_valid, $countones({r_rem_valid, r_empty_err, r_full_drop}) <= 1, "conflicting result flags")
    `SPQ_ASSERT_NXT(a_insert_count, i_clk, i_rst_n, cmd == spq_pkg::CMD_INSERT, r_count == $past(r_count) + 1'b1, "insert did not grow count")

endmodule
